[hw/rtl/kpc_pkg.sv]
package kpc_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int REG_WIDTH   = 8;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [REG_WIDTH-1:0]   t_reg;
    typedef logic [CMP_WIDTH-1:0]   t_cmp;

    typedef enum logic [1:0] {
        REG_SHORT_PRESS = 2'd0,
        REG_LONG_PRESS  = 2'd1,
        REG_TICK_RELOAD = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    localparam t_reg SHORT_PRESS_RESET = 8'd3;
    localparam t_reg LONG_PRESS_RESET  = 8'd100;
    localparam t_reg TICK_RELOAD_RESET = 8'd15;

    // Bit 2 set means no single key is pressed; bits 1..0 are the key.
    typedef logic [2:0] t_key;
    localparam t_key NO_KEY = 3'd4;

    localparam logic [3:0] KEY_PIN_MASK = 4'hf;

    typedef struct packed {
        t_reg short_ticks;
        t_reg long_ticks;
    } t_key_cfg;

    typedef struct packed {
        logic       event_hit;
        logic       pending;
        logic [1:0] id;
        logic       is_long;
    } t_key_report;

    function automatic t_key decode_keys(input logic [3:0] pins);
        t_key key;
        unique case ((~pins) & KEY_PIN_MASK)
            4'b0001: key = 3'd3;
            4'b0010: key = 3'd0;
            4'b0100: key = 3'd1;
            4'b1000: key = 3'd2;
            default: key = NO_KEY;
        endcase
        return key;
    endfunction

endpackage

[hw/rtl/kpc_classifier.sv]
module kpc_classifier (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [3:0]           i_keys_raw,
    input  logic                 i_key_taken,
    input  kpc_pkg::t_key_cfg    i_cfg,
    output kpc_pkg::t_key_report o_report
);

    kpc_pkg::t_key   r_held;
    kpc_pkg::t_key   n_held;
    kpc_pkg::t_count r_count;
    kpc_pkg::t_count n_count;
    logic            r_armed;
    logic            n_armed;
    logic            r_pending;
    logic            n_pending;
    logic [2:0]      r_code;
    logic [2:0]      n_code;
    logic            ev;
    kpc_pkg::t_key   key;

    always_comb begin
        key       = kpc_pkg::decode_keys(i_keys_raw);
        n_pending = r_pending & ~i_key_taken;
        n_code    = r_code;
        n_armed   = r_armed;
        ev        = 1'b0;

        if (key != kpc_pkg::NO_KEY) begin
            n_count = (r_held == key) ? r_count + kpc_pkg::t_count'(1) : '0;
            n_held  = key;
        end else begin
            if (r_armed && !n_pending && (r_held != kpc_pkg::NO_KEY)) begin
                n_pending = 1'b1;
                n_code    = {1'b0, r_held[1:0]};
                ev        = 1'b1;
            end
            n_armed = 1'b0;
            n_held  = kpc_pkg::NO_KEY;
            n_count = '0;
        end

        if (!n_pending && (n_held != kpc_pkg::NO_KEY)) begin
            if (kpc_pkg::t_cmp'(n_count) == kpc_pkg::t_cmp'(i_cfg.short_ticks)) begin
                n_armed = 1'b1;
            end
            if (kpc_pkg::t_cmp'(n_count) == kpc_pkg::t_cmp'(i_cfg.long_ticks)) begin
                n_code    = {1'b1, n_held[1:0]};
                n_pending = 1'b1;
                n_armed   = 1'b0;
                ev        = 1'b1;
            end
        end

        o_report.event_hit = ev;
        o_report.pending   = n_pending;
        o_report.id        = n_pending ? n_code[1:0] : 2'd0;
        o_report.is_long   = n_pending & n_code[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= kpc_pkg::NO_KEY;
            r_count   <= '0;
            r_armed   <= 1'b0;
            r_pending <= 1'b0;
            r_code    <= '0;
        end else if (i_step) begin
            r_held    <= n_held;
            r_count   <= n_count;
            r_armed   <= n_armed;
            r_pending <= n_pending;
            r_code    <= n_code;
        end
    end

endmodule

[hw/rtl/key_press_classifier_ticker.sv]
// Classifies presses on four active-low keys as short or long and divides the
// timer tick into a slower system tick. Each input item is one timer tick; each
// produces exactly one result item. The block takes one item per clock unless
// o_in_stall is high. Each item goes through an input register and the key and
// divider logic into the result register. The user must write registers through
// the plain write port only while no item is in flight (the block does not enforce it).
module key_press_classifier_ticker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_keys_raw,
    input  logic       i_key_taken,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_key_event,
    output logic       o_key_pending,
    output logic [1:0] o_key_id,
    output logic       o_key_long,
    output logic       o_sys_tick,
    output logic       o_wake,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);

    kpc_pkg::t_reg        r_short_ticks;
    kpc_pkg::t_reg        r_long_ticks;
    kpc_pkg::t_reg        r_tick_reload;
    kpc_pkg::t_reg        r_div;
    kpc_pkg::t_reg        n_div;
    logic                 n_tick;
    logic                 r_in_valid;
    logic [3:0]           r_keys_raw;
    logic                 r_key_taken;
    logic                 out_free;
    logic                 step;
    kpc_pkg::t_key_cfg    key_cfg;
    kpc_pkg::t_key_report report;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= kpc_pkg::SHORT_PRESS_RESET;
            r_long_ticks  <= kpc_pkg::LONG_PRESS_RESET;
            r_tick_reload <= kpc_pkg::TICK_RELOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (kpc_pkg::t_reg_idx'(i_cfg_idx))
                kpc_pkg::REG_SHORT_PRESS: r_short_ticks <= i_cfg_wdata;
                kpc_pkg::REG_LONG_PRESS:  r_long_ticks  <= i_cfg_wdata;
                kpc_pkg::REG_TICK_RELOAD: r_tick_reload <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        key_cfg.short_ticks = r_short_ticks;
        key_cfg.long_ticks  = r_long_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_keys_raw  <= i_keys_raw;
            r_key_taken <= i_key_taken;
        end
    end

    kpc_classifier u_classifier (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_keys_raw  (r_keys_raw),
        .i_key_taken (r_key_taken),
        .i_cfg       (key_cfg),
        .o_report    (report)
    );

    always_comb begin
        n_tick = (r_div == '0);
        n_div  = n_tick ? r_tick_reload : r_div - kpc_pkg::t_reg'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= kpc_pkg::TICK_RELOAD_RESET;
            o_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_div <= n_div;
            end
            if (out_free) begin
                o_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_key_event   <= report.event_hit;
            o_key_pending <= report.pending;
            o_key_id      <= report.id;
            o_key_long    <= report.is_long;
            o_sys_tick    <= n_tick;
            o_wake        <= report.event_hit | n_tick;
        end
    end

    a_event_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_event |-> o_key_pending)
        else $error("key report without pending flag");

    a_wake_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wake == (o_key_event || o_sys_tick)))
        else $error("wake does not match key report and system tick");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_key_pending |-> (o_key_id == 2'd0) && !o_key_long)
        else $error("key fields set with no pending report");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && r_in_valid)
        else $error("input stalled while the result register can advance");

endmodule
